### hw/rtl/furc_pkg.sv
package furc_pkg;

	// CRC-32, reflected form
	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	// Command and reply codes
	localparam logic [7:0] CMD_LOAD  = 8'h4C;
	localparam logic [7:0] CMD_DONE  = 8'h44;
	localparam logic [7:0] REPLY_ACK = 8'h41;
	localparam logic [7:0] REPLY_NAK = 8'h4E;

	typedef enum logic [2:0] {
		PH_COMMAND,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CHECK,
		PH_FINISHED
	} phase_t;

	// One CRC byte update: eight shift-and-xor steps
	function automatic logic [31:0] crc_add_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### hw/rtl/furc_crc_byte.sv
module furc_crc_byte
	import furc_pkg::*;
(
	input  logic        restart,
	input  logic [31:0] crc_cur,
	input  logic [7:0]  data,
	output logic [31:0] crc_next
);

	logic [31:0] crc_seed;

	// Start from all ones on a new frame, else carry the running value
	assign crc_seed = restart ? CRC_ALL_ONES : crc_cur;
	assign crc_next = crc_add_byte(crc_seed, data);

endmodule

### hw/rtl/framed_upload_receiver_crc32_unit.sv
// Path: a byte accepted passes the input register, then the result register;
// a stall on the result side can hold it in either.
// Throughput: one byte per cycle while out_stall is low; the byte-wide CRC update
// and the frame state machine are combinational between the two registers.
// Reset: arst_n asynchronous, active low; clears the frame state, the total
// and the write address (to zero) and empties both registers.
module framed_upload_receiver_crc32_unit
	import furc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] base_address,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        mem_write,
	output logic [31:0] mem_address,
	output logic [7:0]  mem_data,
	output logic        reply_valid,
	output logic [7:0]  reply_byte,
	output logic        finished,
	output logic [31:0] byte_total
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        out_valid_s2;
	logic        s2_en;
	logic        s1_take;
	logic        fire;

	phase_t      phase_q, phase_d;
	logic [31:0] crc_q, crc_d, crc_upd;
	logic [7:0]  len_q, len_d;
	logic [7:0]  offset_q, offset_d;
	logic [23:0] rcv_crc_q, rcv_crc_d;
	logic [1:0]  crc_idx_q, crc_idx_d;
	logic [31:0] waddr_q, waddr_d;
	logic [31:0] total_q, total_d;

	logic        wr_c, rv_c, fin_c;
	logic [31:0] addr_c;
	logic [7:0]  data_c, rb_c;

	assign cfg_ready = 1'b1;

	// Handshake: result register moves when empty or not stalled
	assign s2_en    = !out_valid_s2 || !out_stall;
	assign s1_take  = s2_en || !valid_s1;
	assign in_stall = !s1_take;
	assign fire     = valid_s1 && s2_en;
	assign out_valid = out_valid_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// CRC byte update
	furc_crc_byte u_crc (
		.restart  (phase_q == PH_COMMAND),
		.crc_cur  (crc_q),
		.data     (rx_byte_s1),
		.crc_next (crc_upd)
	);

	// Next state and result for the held byte
	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		len_d     = len_q;
		offset_d  = offset_q;
		rcv_crc_d = rcv_crc_q;
		crc_idx_d = crc_idx_q;
		waddr_d   = waddr_q;
		total_d   = total_q;
		wr_c      = 1'b0;
		addr_c    = 32'd0;
		data_c    = 8'd0;
		rv_c      = 1'b0;
		rb_c      = 8'd0;
		fin_c     = 1'b0;
		unique case (phase_q)
			PH_COMMAND: begin
				if (rx_byte_s1 == CMD_LOAD) begin
					crc_d   = crc_upd;
					phase_d = PH_LENGTH;
				end else if (rx_byte_s1 == CMD_DONE) begin
					fin_c   = 1'b1;
					phase_d = PH_FINISHED;
				end
			end
			PH_LENGTH: begin
				crc_d     = crc_upd;
				len_d     = rx_byte_s1;
				offset_d  = 8'd0;
				rcv_crc_d = 24'd0;
				crc_idx_d = 2'd0;
				phase_d   = (rx_byte_s1 == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d    = crc_upd;
				wr_c     = 1'b1;
				addr_c   = waddr_q + {24'd0, offset_q};
				data_c   = rx_byte_s1;
				offset_d = offset_q + 8'd1;
				if (offset_d == len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				unique case (crc_idx_q)
					2'd0: rcv_crc_d[7:0]   = rx_byte_s1;
					2'd1: rcv_crc_d[15:8]  = rx_byte_s1;
					2'd2: rcv_crc_d[23:16] = rx_byte_s1;
					default: ;
				endcase
				if (crc_idx_q == 2'd3) begin
					rv_c = 1'b1;
					if ((crc_q ^ CRC_ALL_ONES) == {rx_byte_s1, rcv_crc_q}) begin
						waddr_d = waddr_q + {24'd0, len_q};
						total_d = total_q + {24'd0, len_q};
						rb_c    = REPLY_ACK;
					end else begin
						rb_c    = REPLY_NAK;
					end
					crc_idx_d = 2'd0;
					phase_d   = PH_COMMAND;
				end else begin
					crc_idx_d = crc_idx_q + 2'd1;
				end
			end
			PH_FINISHED: ;
			default: phase_d = phase_q;
		endcase
	end

	// State register: advance on each processed byte, load address on config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COMMAND;
			crc_q     <= CRC_ALL_ONES;
			len_q     <= 8'd0;
			offset_q  <= 8'd0;
			rcv_crc_q <= 24'd0;
			crc_idx_q <= 2'd0;
			waddr_q   <= 32'd0;
			total_q   <= 32'd0;
		end else begin
			if (fire) begin
				phase_q   <= phase_d;
				crc_q     <= crc_d;
				len_q     <= len_d;
				offset_q  <= offset_d;
				rcv_crc_q <= rcv_crc_d;
				crc_idx_q <= crc_idx_d;
				waddr_q   <= waddr_d;
				total_q   <= total_d;
			end
			if (cfg_valid && cfg_ready) begin
				waddr_q <= base_address;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s2_en) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mem_write   <= wr_c;
			mem_address <= addr_c;
			mem_data    <= data_c;
			reply_valid <= rv_c;
			reply_byte  <= rb_c;
			finished    <= fin_c;
			byte_total  <= total_d;
		end
	end

	// Checks
	a_write_xor_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(mem_write && reply_valid))
		else $error("payload write and reply in one result");

	a_reply_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && reply_valid) |-> (reply_byte == REPLY_ACK || reply_byte == REPLY_NAK))
		else $error("bad reply code");

	a_finish_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && fin_c) |=> (phase_q == PH_FINISHED))
		else $error("finish without entering finished state");

	a_total_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rb_c != REPLY_ACK) |=> $stable(total_q))
		else $error("total changed without acknowledge");

endmodule

### dv/framed_upload_receiver_crc32_unit_test.sv
`timescale 1ns / 100ps

module framed_upload_receiver_crc32_unit_test
	import furc_pkg::*;
();

	localparam int CYCLE_LIMIT = 300000;

	// One result as the block presents it
	typedef struct packed {
		logic        mem_write;
		logic [31:0] mem_address;
		logic [7:0]  mem_data;
		logic        reply_valid;
		logic [7:0]  reply_byte;
		logic        finished;
		logic [31:0] byte_total;
	} upload_result_t;

	// Frame receiver prediction and the results still owed by the block
	class upload_checker;
		phase_t         phase;
		logic [31:0]    crc_acc;
		logic [7:0]     frame_len;
		logic [7:0]     offset;
		logic [31:0]    crc_rx;
		logic [1:0]     crc_idx;
		logic [31:0]    write_addr;
		logic [31:0]    total;
		upload_result_t pending_results[$];
		int             errors;

		function new();
			phase = PH_COMMAND;
			crc_acc = CRC_ALL_ONES;
			frame_len = '0;
			offset = '0;
			crc_rx = '0;
			crc_idx = '0;
			write_addr = '0;
			total = '0;
			errors = 0;
		endfunction

		// Bit-serial reflected CRC, one bit of the byte at a time
		static function logic [31:0] crc_fold(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			logic        fb;
			r = c;
			for (int i = 0; i < 8; i++) begin
				fb = r[0] ^ b[i];
				r = r >> 1;
				if (fb)
					r = r ^ CRC_POLY;
			end
			return r;
		endfunction

		function void write_base(logic [31:0] a);
			write_addr = a;
		endfunction

		function upload_result_t predict_byte(logic [7:0] b);
			upload_result_t r;
			r = '0;
			case (phase)
				PH_COMMAND: begin
					if (b == CMD_LOAD) begin
						crc_acc = crc_fold(CRC_ALL_ONES, b);
						phase = PH_LENGTH;
					end else if (b == CMD_DONE) begin
						r.finished = 1'b1;
						phase = PH_FINISHED;
					end
				end
				PH_LENGTH: begin
					crc_acc = crc_fold(crc_acc, b);
					frame_len = b;
					offset = '0;
					crc_rx = '0;
					crc_idx = '0;
					phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					crc_acc = crc_fold(crc_acc, b);
					r.mem_write = 1'b1;
					r.mem_address = write_addr + 32'(offset);
					r.mem_data = b;
					offset = offset + 8'd1;
					if (offset == frame_len)
						phase = PH_CHECK;
				end
				PH_CHECK: begin
					// gather the CRC little-endian, judge on the last byte
					crc_rx = crc_rx | (32'(b) << (8 * crc_idx));
					if (crc_idx == 2'd3) begin
						r.reply_valid = 1'b1;
						if ((crc_acc ^ CRC_ALL_ONES) == crc_rx) begin
							write_addr = write_addr + 32'(frame_len);
							total = total + 32'(frame_len);
							r.reply_byte = REPLY_ACK;
						end else begin
							r.reply_byte = REPLY_NAK;
						end
						crc_idx = '0;
						phase = PH_COMMAND;
					end else begin
						crc_idx = crc_idx + 2'd1;
					end
				end
				default: begin
				end
			endcase
			r.byte_total = total;
			return r;
		endfunction

		function void note_byte(logic [7:0] b);
			pending_results.push_back(predict_byte(b));
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t: %s: got %h, expected %h", $time, what, got, want);
			errors++;
		endtask

		task check_result(upload_result_t got);
			upload_result_t want;
			if (pending_results.size() == 0) begin
				report("result with nothing pending", got.byte_total, 32'd0);
				return;
			end
			want = pending_results.pop_front();
			if (got.mem_write !== want.mem_write)
				report("mem_write", 32'(got.mem_write), 32'(want.mem_write));
			if (got.mem_address !== want.mem_address)
				report("mem_address", got.mem_address, want.mem_address);
			if (got.mem_data !== want.mem_data)
				report("mem_data", 32'(got.mem_data), 32'(want.mem_data));
			if (got.reply_valid !== want.reply_valid)
				report("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
			if (got.reply_byte !== want.reply_byte)
				report("reply_byte", 32'(got.reply_byte), 32'(want.reply_byte));
			if (got.finished !== want.finished)
				report("finished", 32'(got.finished), 32'(want.finished));
			if (got.byte_total !== want.byte_total)
				report("byte_total", got.byte_total, want.byte_total);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] base_address;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        mem_write;
	logic [31:0] mem_address;
	logic [7:0]  mem_data;
	logic        reply_valid;
	logic [7:0]  reply_byte;
	logic        finished;
	logic [31:0] byte_total;

	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int sent_count = 0;
	int cycle_count = 0;

	// chk follows accepted requests; plan follows the stream as it is generated
	upload_checker chk = new();
	upload_checker plan = new();

	framed_upload_receiver_crc32_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.base_address(base_address),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mem_write   (mem_write),
		.mem_address (mem_address),
		.mem_data    (mem_data),
		.reply_valid (reply_valid),
		.reply_byte  (reply_byte),
		.finished    (finished),
		.byte_total  (byte_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < out_stall_pct);
	end

	// Watch every handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				chk.write_base(base_address);
			if (in_valid && !in_stall)
				chk.note_byte(rx_byte);
			if (out_valid && !out_stall)
				chk.check_result({mem_write, mem_address, mem_data, reply_valid,
					reply_byte, finished, byte_total});
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("framed_upload_receiver_crc32_unit_test: done, errors");
			$finish;
		end
	end

	// Drive one request and hold it until the block takes it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Keep the done command out of the stream until the very end
	task automatic send_planned(input logic [7:0] b, input bit allow_done = 1'b0);
		logic [7:0] v;
		v = b;
		if (!allow_done && plan.phase == PH_COMMAND && v == CMD_DONE)
			v = v ^ 8'h01;
		void'(plan.predict_byte(v));
		sent_count++;
		send_byte(v);
	endtask

	// Build a frame, optionally spoil its CRC or cut it short
	task automatic send_frame(input logic [7:0] payload[$], input bit good, input int keep);
		logic [7:0]  frame[$];
		logic [31:0] crc;
		frame.push_back(CMD_LOAD);
		frame.push_back(8'(payload.size()));
		foreach (payload[i])
			frame.push_back(payload[i]);
		crc = CRC_ALL_ONES;
		foreach (frame[i])
			crc = upload_checker::crc_fold(crc, frame[i]);
		crc = crc ^ CRC_ALL_ONES;
		if (!good)
			crc = crc ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			frame.push_back(crc[8*i +: 8]);
		if (keep >= 0)
			while (frame.size() > keep)
				void'(frame.pop_back());
		foreach (frame[i])
			send_planned(frame[i]);
	endtask

	// Feed filler until the block waits for a command again
	task automatic resync();
		while (plan.phase != PH_COMMAND) begin
			if (plan.phase == PH_LENGTH)
				send_planned(8'($urandom_range(0, 3)));
			else
				send_planned(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_payload(output logic [7:0] payload[$], input int len);
		payload = {};
		repeat (len)
			payload.push_back(8'($urandom_range(0, 255)));
	endtask

	// Mostly whole frames, some with a bad CRC, some cut short, some line noise
	task automatic random_traffic(input int n);
		int         stop_at;
		int         kind;
		int         len;
		logic [7:0] payload[$];
		stop_at = sent_count + n;
		while (sent_count < stop_at) begin
			kind = $urandom_range(0, 99);
			if ($urandom_range(0, 39) == 0)
				len = $urandom_range(0, 1) ? 255 : $urandom_range(13, 254);
			else
				len = $urandom_range(0, 12);
			random_payload(payload, len);
			if (kind < 70) begin
				resync();
				send_frame(payload, $urandom_range(0, 4) != 0, -1);
			end else if (kind < 82) begin
				resync();
				send_frame(payload, 1'b1, $urandom_range(1, len + 5));
			end else begin
				repeat ($urandom_range(1, 4))
					send_planned(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Leave the block in the middle of a payload
	task automatic partial_frame();
		logic [7:0] payload[$];
		int         len;
		len = $urandom_range(3, 12);
		random_payload(payload, len);
		resync();
		send_frame(payload, 1'b1, $urandom_range(3, len + 1));
	endtask

	task automatic write_base_address(input logic [31:0] a);
		cfg_valid <= 1'b1;
		base_address <= a;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		plan.write_base(a);
	endtask

	// Drop valid and wait for every owed result, then let the pipeline settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk.pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic directed_frames();
		logic [7:0] payload[$];
		// unknown commands, both extremes
		send_planned(8'h00);
		send_planned(8'hFF);
		// zero length frame, good CRC
		payload = {};
		send_frame(payload, 1'b1, -1);
		// one byte, all ones, bad CRC
		payload.push_back(8'hFF);
		send_frame(payload, 1'b0, -1);
		// resend with one zero payload byte, good CRC
		payload[0] = 8'h00;
		send_frame(payload, 1'b1, -1);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		base_address = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		in_idle_pct = 19;
		out_stall_pct = 78;
		write_base_address(32'h0000_0000);
		directed_frames();
		wait_drained();
		write_base_address(32'($urandom));
		random_traffic(590);
		partial_frame();

		wait_drained();
		in_idle_pct = 78;
		out_stall_pct = 19;
		write_base_address(32'hFFFF_FFF8);
		random_traffic(590);
		partial_frame();

		wait_drained();
		in_idle_pct = 0;
		out_stall_pct = 0;
		write_base_address(32'hFFFF_FFFF);
		random_traffic(590);

		// end the upload, then check that later bytes are ignored
		resync();
		send_planned(CMD_DONE, 1'b1);
		send_planned(CMD_LOAD, 1'b1);
		send_planned(8'h00, 1'b1);
		send_planned(CMD_DONE, 1'b1);
		send_planned(8'hFF, 1'b1);
		wait_drained();
		repeat (10) @(posedge clk);

		if (chk.pending_results.size() != 0)
			chk.report("results never produced", chk.pending_results.size(), 32'd0);
		if (chk.errors == 0) begin
			$display("framed_upload_receiver_crc32_unit_test: done, clean");
		end else begin
			$display("framed_upload_receiver_crc32_unit_test: done, errors");
		end
		$finish;
	end

endmodule

### framed_upload_receiver_crc32_unit.f
hw/rtl/furc_pkg.sv
hw/rtl/furc_crc_byte.sv
hw/rtl/framed_upload_receiver_crc32_unit.sv
dv/framed_upload_receiver_crc32_unit_test.sv
